>>> hdl/tslf_pkg.sv
// Shared types, constants and character codes for the text stream line formatter.
package tslf_pkg;

   localparam int NumberDigits = 6;
   localparam int BodyMax      = 4;
   localparam int RunLen       = NumberDigits + 1 + BodyMax;
   localparam int CountWidth   = $clog2(RunLen + 1);
   localparam int BodyLenWidth = $clog2(BodyMax + 1);
   localparam int RegCount     = 6;
   localparam int AddrWidth    = $clog2(RegCount * 4);
   localparam int IndexWidth   = AddrWidth - 2;

   typedef enum logic [IndexWidth-1:0] {
      RegNumberNonblank  = IndexWidth'(0),
      RegNumberAll       = IndexWidth'(1),
      RegSqueezeBlank    = IndexWidth'(2),
      RegShowTabs        = IndexWidth'(3),
      RegShowEnds        = IndexWidth'(4),
      RegShowNonprinting = IndexWidth'(5)
   } reg_index_type;

   localparam logic [7:0] CharTab      = 8'h09;
   localparam logic [7:0] CharNewline  = 8'h0A;
   localparam logic [7:0] CharSpace    = 8'h20;
   localparam logic [7:0] CharDollar   = 8'h24;
   localparam logic [7:0] CharDash     = 8'h2D;
   localparam logic [7:0] CharZero     = 8'h30;
   localparam logic [7:0] CharQuestion = 8'h3F;
   localparam logic [7:0] CharUpperI   = 8'h49;
   localparam logic [7:0] CharUpperM   = 8'h4D;
   localparam logic [7:0] CharCaret    = 8'h5E;
   localparam logic [6:0] CharDelete   = 7'h7F;
   localparam logic [7:0] CaretOffset  = 8'd64;
   localparam logic [6:0] ControlLimit = 7'd32;

   typedef struct packed {
      logic number_nonblank;
      logic number_all;
      logic squeeze_blank;
      logic show_tabs;
      logic show_ends;
      logic show_nonprinting;
   } cfg_type;

   typedef struct packed {
      logic [CountWidth-1:0]     len;
      logic [RunLen-1:0][7:0]    bytes;
   } run_type;

   typedef struct packed {
      logic                  free;
      logic [CountWidth-1:0] count;
   } emit_status_type;

endpackage

>>> hdl/tslf_csr.sv
// APB-style configuration registers of the text stream line formatter.
module tslf_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tslf_pkg::AddrWidth-1:0]  paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output tslf_pkg::cfg_type               cfg
);
   import tslf_pkg::*;

   cfg_type                 cfg_ff;
   logic [IndexWidth-1:0]   index;
   logic                    wr_en;
   logic                    rd_bit;

   assign index  = paddr[AddrWidth-1:2];
   assign wr_en  = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_en) begin
         unique case (index)
            RegNumberNonblank:  cfg_ff.number_nonblank  <= pwdata[0];
            RegNumberAll:       cfg_ff.number_all       <= pwdata[0];
            RegSqueezeBlank:    cfg_ff.squeeze_blank    <= pwdata[0];
            RegShowTabs:        cfg_ff.show_tabs        <= pwdata[0];
            RegShowEnds:        cfg_ff.show_ends        <= pwdata[0];
            RegShowNonprinting: cfg_ff.show_nonprinting <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         RegNumberNonblank:  rd_bit = cfg_ff.number_nonblank;
         RegNumberAll:       rd_bit = cfg_ff.number_all;
         RegSqueezeBlank:    rd_bit = cfg_ff.squeeze_blank;
         RegShowTabs:        rd_bit = cfg_ff.show_tabs;
         RegShowEnds:        rd_bit = cfg_ff.show_ends;
         RegShowNonprinting: rd_bit = cfg_ff.show_nonprinting;
         default:            rd_bit = 1'b0;
      endcase
   end

   assign prdata = {31'b0, rd_bit};

endmodule

>>> hdl/tslf_decode.sv
// Line state, decimal line counter and expansion of one byte into its output run.
module tslf_decode (
   input  logic              clock,
   input  logic              reset,
   input  tslf_pkg::cfg_type cfg,
   input  logic              load,
   input  logic              first_of_file,
   input  logic [7:0]        in_byte,
   output tslf_pkg::run_type run
);
   import tslf_pkg::*;

   // Line number kept as BCD digits, digit 0 least significant.
   logic [NumberDigits-1:0][3:0] num_ff, num_in, eff_num, inc_num;
   logic                         prev_nl_ff, prev_nl_in, eff_prev_nl;
   logic                         blank_ff, blank_in, eff_blank;
   logic                         is_nl, is_tab, squeeze, do_num, all_nines, carry, zero_run;
   logic [NumberDigits-1:0][7:0] digit_chars;
   logic [BodyMax-1:0][7:0]      body;
   logic [BodyLenWidth-1:0]      body_len, lo_len;
   logic [7:0]                   lo0, lo1;
   logic [6:0]                   low7;
   logic [3:0]                   dig;

   assign is_nl  = (in_byte == CharNewline);
   assign is_tab = (in_byte == CharTab);

   // A first-of-file mark restarts the line state before this byte is judged.
   always_comb begin
      eff_num = '0;
      if (first_of_file) begin
         eff_num[0]  = 4'd1;
         eff_prev_nl = 1'b1;
         eff_blank   = 1'b0;
      end else begin
         eff_num     = num_ff;
         eff_prev_nl = prev_nl_ff;
         eff_blank   = blank_ff;
      end
   end

   assign squeeze = cfg.squeeze_blank && eff_prev_nl && is_nl && eff_blank;
   assign do_num  = eff_prev_nl &&
                    (cfg.number_nonblank ? !is_nl : cfg.number_all);

   always_comb begin
      all_nines = 1'b1;
      carry     = 1'b1;
      inc_num   = eff_num;
      for (int i = 0; i < NumberDigits; i++) begin
         all_nines = all_nines && (eff_num[i] == 4'd9);
         if (carry) begin
            if (eff_num[i] == 4'd9) begin
               inc_num[i] = 4'd0;
            end else begin
               inc_num[i] = eff_num[i] + 4'd1;
               carry      = 1'b0;
            end
         end
      end
   end

   // Leading zeros print as spaces; the last digit always prints.
   always_comb begin
      zero_run = 1'b1;
      dig      = '0;
      for (int k = 0; k < NumberDigits; k++) begin
         dig      = eff_num[NumberDigits-1-k];
         zero_run = zero_run && (dig == 4'd0);
         if (zero_run && (k != NumberDigits - 1)) begin
            digit_chars[k] = CharSpace;
         end else begin
            digit_chars[k] = CharZero + {4'd0, dig};
         end
      end
   end

   // Caret form of the low seven bits, used by the nonprinting display.
   always_comb begin
      low7 = in_byte[6:0];
      lo1  = '0;
      if (low7 < ControlLimit) begin
         lo0    = CharCaret;
         lo1    = {1'b0, low7} + CaretOffset;
         lo_len = BodyLenWidth'(2);
      end else if (low7 == CharDelete) begin
         lo0    = CharCaret;
         lo1    = CharQuestion;
         lo_len = BodyLenWidth'(2);
      end else begin
         lo0    = {1'b0, low7};
         lo_len = BodyLenWidth'(1);
      end
   end

   always_comb begin
      body = '0;
      priority if (cfg.show_tabs && is_tab) begin
         body[0]  = CharCaret;
         body[1]  = CharUpperI;
         body_len = BodyLenWidth'(2);
      end else if (cfg.show_ends && is_nl) begin
         body[0]  = CharDollar;
         body[1]  = CharNewline;
         body_len = BodyLenWidth'(2);
      end else if (cfg.show_nonprinting && !is_nl && !is_tab) begin
         if (in_byte[7]) begin
            body[0]  = CharUpperM;
            body[1]  = CharDash;
            body[2]  = lo0;
            body[3]  = lo1;
            body_len = BodyLenWidth'(2) + lo_len;
         end else begin
            body[0]  = lo0;
            body[1]  = lo1;
            body_len = lo_len;
         end
      end else begin
         body[0]  = in_byte;
         body_len = BodyLenWidth'(1);
      end
   end

   always_comb begin
      run.bytes = '0;
      if (squeeze) begin
         run.len = '0;
      end else if (do_num) begin
         run.len = CountWidth'(NumberDigits + 1) + CountWidth'(body_len);
         for (int k = 0; k < NumberDigits; k++) begin
            run.bytes[k] = digit_chars[k];
         end
         run.bytes[NumberDigits] = CharTab;
         for (int k = 0; k < BodyMax; k++) begin
            run.bytes[NumberDigits+1+k] = body[k];
         end
      end else begin
         run.len = CountWidth'(body_len);
         for (int k = 0; k < BodyMax; k++) begin
            run.bytes[k] = body[k];
         end
      end
   end

   always_comb begin
      if (squeeze) begin
         prev_nl_in = eff_prev_nl;
         blank_in   = eff_blank;
         num_in     = eff_num;
      end else begin
         prev_nl_in = is_nl;
         blank_in   = eff_prev_nl && is_nl;
         num_in     = (do_num && !all_nines) ? inc_num : eff_num;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_nl_ff <= 1'b1;
         blank_ff   <= 1'b0;
         num_ff     <= {{(NumberDigits-1){4'd0}}, 4'd1};
      end else if (load) begin
         prev_nl_ff <= prev_nl_in;
         blank_ff   <= blank_in;
         num_ff     <= num_in;
      end
   end

endmodule

>>> hdl/tslf_emit.sv
// Result shift register that sends one output byte per transfer.
module tslf_emit (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load,
   input  tslf_pkg::run_type         run,
   input  logic                      rsp_ready,
   output logic                      rsp_valid,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_last_of_run,
   output tslf_pkg::emit_status_type status
);
   import tslf_pkg::*;

   logic [CountWidth-1:0]  count_ff;
   logic [RunLen-1:0][7:0] bytes_ff;
   logic                   take;

   assign rsp_valid       = (count_ff != '0);
   assign rsp_out_byte    = bytes_ff[0];
   assign rsp_last_of_run = (count_ff == CountWidth'(1));
   assign take            = rsp_valid && rsp_ready;
   assign status.free     = !rsp_valid || (take && rsp_last_of_run);
   assign status.count    = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (load) begin
         count_ff <= run.len;
      end else if (take) begin
         count_ff <= count_ff - CountWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bytes_ff <= run.bytes;
      end else if (take) begin
         bytes_ff <= bytes_ff >> 8;
      end
   end

endmodule

>>> hdl/text_stream_line_formatter.sv
// Top level of the text stream line formatter: input register, decode and result emitter.
// Each accepted byte is held in an input register, then expanded combinationally into a run of
// zero to eleven output bytes (an optional six-digit line number and tab, then the byte or its
// visible form) that is loaded into a result shift register. The shift register sends one
// byte per cycle while rsp_ready is high, so a plain byte passes at one item per cycle when
// the output does not stall. Each byte passes the input register and then the result shift
// register before its first result byte appears. A squeezed blank line yields no bytes. The
// input register, when empty, accepts a new byte while a result still waits to be taken.
module text_stream_line_formatter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_first_of_file,
   input  logic [7:0]                      req_in_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_out_byte,
   output logic                            rsp_last_of_run,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [tslf_pkg::AddrWidth-1:0]  paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import tslf_pkg::*;

   cfg_type         cfg;
   run_type         run;
   emit_status_type emit_status;
   logic            in_valid_ff, in_valid_in;
   logic            in_fof_ff;
   logic [7:0]      in_byte_ff;
   logic            load, req_take;

   assign load      = in_valid_ff && emit_status.free;
   assign req_ready = !in_valid_ff || load;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (load) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_fof_ff  <= req_first_of_file;
         in_byte_ff <= req_in_byte;
      end
   end

   tslf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tslf_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .load          (load),
      .first_of_file (in_fof_ff),
      .in_byte       (in_byte_ff),
      .run           (run)
   );

   tslf_emit u_emit (
      .clock           (clock),
      .reset           (reset),
      .load            (load),
      .run             (run),
      .rsp_ready       (rsp_ready),
      .rsp_valid       (rsp_valid),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run),
      .status          (emit_status)
   );

   // The pending run never holds more bytes than the longest expansion.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      emit_status.count <= CountWidth'(RunLen))
      else $error("result run longer than the longest expansion");

   // Once the last byte of a run is transferred and nothing new is loaded, the output drains.
   a_run_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_of_run && !load) |=> !rsp_valid)
      else $error("output still valid after the last byte of a run");

   // An empty input register always takes a new byte.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_ready)
      else $error("input register empty but not ready");

endmodule
